// ----- sv/tqr_pkg.sv -----
// Package: shared types, codes and fixed thresholds of the temperature read qualifier.
package tqr_pkg;

  // Temperature in signed sixteenths of a degree
  typedef logic signed [11:0] temp_t;

  // Command codes on the input channel
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_INIT  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // Readback classes
  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_VALID = 3'd1,
    CLS_BOOT  = 3'd2,
    CLS_DISC  = 3'd3,
    CLS_RANGE = 3'd4
  } class_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BOOT_IGNORE   = 2'd0,
    REG_READ_INTERVAL = 2'd1,
    REG_CONV_WAIT     = 2'd2
  } reg_e;

  // Thresholds in sixteenths of a degree
  localparam temp_t DiscLimit = -12'sd2016; // -126.0
  localparam temp_t HotLow    = 12'sd1359;  // 85.0 less one step
  localparam temp_t HotHigh   = 12'sd1361;  // 85.0 plus one step
  localparam temp_t LowLimit  = -12'sd640;  // -40.0
  localparam temp_t HighLimit = 12'sd2000;  // 125.0
  localparam temp_t ResetTemp = 12'sd400;   // 25.0

  // Register reset values in ticks
  localparam logic [15:0] BootIgnoreReset   = 16'd1000;
  localparam logic [15:0] ReadIntervalReset = 16'd1000;
  localparam logic [15:0] ConvWaitReset     = 16'd800;

  typedef struct packed {
    logic [1:0] command;
    temp_t      sensor_reading;
    logic       sensor_found;
  } in_item_t;

  typedef struct packed {
    temp_t       temperature;
    logic        ready_flag;
    logic        disconnected_flag;
    logic        reconnected_flag;
    logic        boot_window_active;
    logic        request_conversion;
    logic [2:0]  read_class;
    logic [31:0] disconnect_total;
    logic [31:0] reads_total;
    logic [31:0] reads_valid;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_item_t;

endpackage

// ----- sv/tqr_stream_if.sv -----
// Interface: valid/ready channel carrying one payload item per transfer.
interface tqr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/tqr_classify.sv -----
// Module: sorts one readback value into its class.
module tqr_classify (
  input  tqr_pkg::temp_t  reading_i,
  input  logic            boot_active_i,
  output tqr_pkg::class_e class_o
);
  import tqr_pkg::*;

  // Disconnect wins, then the boot sentinel, then the range check
  always_comb begin
    if (reading_i <= DiscLimit) begin
      class_o = CLS_DISC;
    end else if (boot_active_i && reading_i >= HotLow && reading_i <= HotHigh) begin
      class_o = CLS_BOOT;
    end else if (reading_i < LowLimit || reading_i > HighLimit) begin
      class_o = CLS_RANGE;
    end else begin
      class_o = CLS_VALID;
    end
  end

endmodule

// ----- sv/temperature_read_qualifier_unit.sv -----
// Each input item is registered in the input stage, then its result in the result stage on res_o.
// Throughput: one item per cycle; the input stalls only while a result waits on res_o
// and the input register is also full. Each item updates the state as it enters the result stage.
// Reset (rst_ni low, asynchronous) clears all qualifier state, sets the stored temperature
// to 25 degrees and loads the register defaults 1000, 1000 and 800 ticks.
module temperature_read_qualifier_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  tqr_stream_if.sink   cfg_i,
  tqr_stream_if.sink   in_i,
  tqr_stream_if.source res_o
);
  import tqr_pkg::*;

  // Configuration registers
  logic [15:0] boot_ignore_q, read_interval_q, conv_wait_q;

  // Input stage
  logic      s1_valid_q;
  in_item_t  s1_item_q;

  // Result stage
  logic      res_valid_q;
  out_item_t res_q, res_d;

  // Qualifier state
  logic [31:0] time_q, time_d;
  logic [31:0] boot_start_q, boot_start_d;
  logic [31:0] last_req_q, last_req_d;
  logic        boot_done_q, boot_done_d;
  logic        conv_q, conv_d;
  logic        have_valid_q, have_valid_d;
  logic        disc_q, disc_d;
  logic        reconn_q, reconn_d;
  temp_t       temp_q, temp_d;
  logic [31:0] disc_cnt_q, disc_cnt_d;
  logic [31:0] read_cnt_q, read_cnt_d;
  logic [31:0] valid_cnt_q, valid_cnt_d;

  logic        advance;
  logic [31:0] now;
  logic [31:0] since_boot;
  logic [31:0] since_req;
  logic        boot_done_tick;
  class_e      rd_class;

  // Handshakes
  assign advance     = s1_valid_q && (!res_valid_q || res_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  // Hold the configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_ignore_q   <= BootIgnoreReset;
      read_interval_q <= ReadIntervalReset;
      conv_wait_q     <= ConvWaitReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        REG_BOOT_IGNORE:   boot_ignore_q   <= cfg_i.data.data;
        REG_READ_INTERVAL: read_interval_q <= cfg_i.data.data;
        REG_CONV_WAIT:     conv_wait_q     <= cfg_i.data.data;
        default: ;
      endcase
    end
  end

  // Capture an input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= in_i.data;
    end
  end

  // Tick timing
  assign now            = time_q + 32'd1;
  assign since_boot     = now - boot_start_q;
  assign since_req      = now - last_req_q;
  assign boot_done_tick = boot_done_q || (since_boot >= {16'd0, boot_ignore_q});

  tqr_classify u_classify (
    .reading_i     (s1_item_q.sensor_reading),
    .boot_active_i (!boot_done_tick),
    .class_o       (rd_class)
  );

  // Next state and result for the item in the input stage
  always_comb begin
    logic   readback;
    logic   request;
    class_e cls;

    time_d       = time_q;
    boot_start_d = boot_start_q;
    last_req_d   = last_req_q;
    boot_done_d  = boot_done_q;
    conv_d       = conv_q;
    have_valid_d = have_valid_q;
    disc_d       = disc_q;
    reconn_d     = reconn_q;
    temp_d       = temp_q;
    disc_cnt_d   = disc_cnt_q;
    read_cnt_d   = read_cnt_q;
    valid_cnt_d  = valid_cnt_q;
    readback     = 1'b0;
    request      = 1'b0;
    cls          = CLS_NONE;

    unique case (cmd_e'(s1_item_q.command))
      CMD_TICK: begin
        time_d      = now;
        boot_done_d = boot_done_tick;
        readback    = conv_q && (since_req >= {16'd0, conv_wait_q});
        if (readback) begin
          read_cnt_d = read_cnt_q + 32'd1;
          cls        = rd_class;
          if (rd_class == CLS_VALID) begin
            temp_d       = s1_item_q.sensor_reading;
            have_valid_d = 1'b1;
            valid_cnt_d  = valid_cnt_q + 32'd1;
            if (disc_q) begin
              disc_d   = 1'b0;
              reconn_d = 1'b1;
            end
          end else if (rd_class == CLS_DISC) begin
            if (!disc_q) begin
              disc_d     = 1'b1;
              disc_cnt_d = disc_cnt_q + 32'd1;
            end
            have_valid_d = 1'b0;
          end
        end
        // Request a new conversion once none is pending and the read interval has passed
        request = (!conv_q || readback) && (since_req >= {16'd0, read_interval_q});
        if (request) begin
          last_req_d = now;
        end
        conv_d = request || (conv_q && !readback);
      end
      CMD_INIT: begin
        boot_start_d = time_q;
        boot_done_d  = 1'b0;
        if (!s1_item_q.sensor_found) begin
          disc_d     = 1'b1;
          disc_cnt_d = disc_cnt_q + 32'd1;
        end
      end
      CMD_CLEAR: begin
        reconn_d = 1'b0;
      end
      default: ;
    endcase

    res_d.temperature        = temp_d;
    res_d.ready_flag         = have_valid_d && !disc_d;
    res_d.disconnected_flag  = disc_d;
    res_d.reconnected_flag   = reconn_d;
    res_d.boot_window_active = !boot_done_d;
    res_d.request_conversion = request;
    res_d.read_class         = cls;
    res_d.disconnect_total   = disc_cnt_d;
    res_d.reads_total        = read_cnt_d;
    res_d.reads_valid        = valid_cnt_d;
  end

  // Advance the state on each processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q       <= '0;
      boot_start_q <= '0;
      last_req_q   <= '0;
      boot_done_q  <= 1'b0;
      conv_q       <= 1'b0;
      have_valid_q <= 1'b0;
      disc_q       <= 1'b0;
      reconn_q     <= 1'b0;
      temp_q       <= ResetTemp;
      disc_cnt_q   <= '0;
      read_cnt_q   <= '0;
      valid_cnt_q  <= '0;
    end else if (advance) begin
      time_q       <= time_d;
      boot_start_q <= boot_start_d;
      last_req_q   <= last_req_d;
      boot_done_q  <= boot_done_d;
      conv_q       <= conv_d;
      have_valid_q <= have_valid_d;
      disc_q       <= disc_d;
      reconn_q     <= reconn_d;
      temp_q       <= temp_d;
      disc_cnt_q   <= disc_cnt_d;
      read_cnt_q   <= read_cnt_d;
      valid_cnt_q  <= valid_cnt_d;
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

endmodule
